[rtl/chuff_pkg.sv]
// ----------------------------------------------------------------------------
// chuff_pkg
// Shared constants, request kinds and interface types of the canonical
// Huffman encoder.
// ----------------------------------------------------------------------------
package chuff_pkg;

    // Field widths.
    localparam int unsigned SYM_W  = 8;
    localparam int unsigned LEN_W  = 6;
    localparam int unsigned CODE_W = 32;
    localparam int unsigned KIND_W = 2;

    // Alphabet size and longest code that the table accepts.
    localparam int unsigned SYMBOL_COUNT = 256;
    localparam int unsigned MAX_CODE_LEN = 32;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ASSIGN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

    // Write port of the code table, driven by a successful assign.
    typedef struct packed {
        logic              en;
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_tbl_wr;

    // Registered table lookup for the request in the work stage.
    typedef struct packed {
        logic              hit;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_tbl_rd;

    // Up to four results produced by one request.
    typedef struct packed {
        logic            any;
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            byte_valid;
        logic            error;
    } t_packet;

endpackage

[rtl/chuff_table.sv]
// ----------------------------------------------------------------------------
// chuff_table
// Code and length table with per-symbol assigned bits and a forwarding path
// for an assign that is written while the next request reads the table.
// ----------------------------------------------------------------------------
module chuff_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [chuff_pkg::SYM_W-1:0]   i_rd_sym,
    input  chuff_pkg::t_tbl_wr            i_wr,
    output chuff_pkg::t_tbl_rd            o_rd
);

    localparam int unsigned DATA_W = chuff_pkg::LEN_W + chuff_pkg::CODE_W;

    logic [DATA_W-1:0]                  r_mem [chuff_pkg::SYMBOL_COUNT];
    logic [chuff_pkg::SYMBOL_COUNT-1:0] r_assigned;
    logic [DATA_W-1:0]                  r_rd_data;
    logic [DATA_W-1:0]                  r_fwd_data;
    logic                               r_fwd;
    logic                               r_hit;
    logic                               fwd_match;

    // The write in flight targets the symbol being read.
    assign fwd_match = i_wr.en && (i_wr.sym == i_rd_sym);

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.sym] <= {i_wr.len, i_wr.code};
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_sym];
            r_fwd_data <= {i_wr.len, i_wr.code};
            r_fwd      <= fwd_match;
        end
    end

    // Assigned bits, cleared at reset so unassigned symbols read with hit low.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_assigned <= '0;
            r_hit      <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_assigned[i_wr.sym] <= 1'b1;
            end
            if (i_rd_en) begin
                r_hit <= r_assigned[i_rd_sym] | fwd_match;
            end
        end
    end

    // Lookup result, taking the forwarded entry when it is newer.
    always_comb begin
        o_rd.hit = r_hit;
        if (r_fwd) begin
            {o_rd.len, o_rd.code} = r_fwd_data;
        end else begin
            {o_rd.len, o_rd.code} = r_rd_data;
        end
    end

endmodule

[rtl/chuff_core.sv]
// ----------------------------------------------------------------------------
// chuff_core
// Work stage: holds the accepted request, assigns canonical codes, packs
// encoded bits into bytes and handles flush.
// ----------------------------------------------------------------------------
module chuff_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [chuff_pkg::KIND_W-1:0]   i_kind,
    input  logic [chuff_pkg::SYM_W-1:0]    i_symbol,
    input  logic [chuff_pkg::LEN_W-1:0]    i_code_length,
    input  chuff_pkg::t_tbl_rd             i_rd,
    input  logic                           i_out_ready,
    output logic                           o_busy,
    output chuff_pkg::t_tbl_wr             o_wr,
    output chuff_pkg::t_packet             o_pkt,
    output logic                           o_load
);

    logic                          r_s1_valid;
    logic [chuff_pkg::KIND_W-1:0]  r_kind;
    logic [chuff_pkg::SYM_W-1:0]   r_sym;
    logic [chuff_pkg::LEN_W-1:0]   r_len;
    logic [chuff_pkg::CODE_W:0]    r_run_code;
    logic [chuff_pkg::LEN_W-1:0]   r_run_len;
    logic [6:0]                    r_buf;
    logic [2:0]                    r_cnt;

    logic [chuff_pkg::CODE_W:0]    n_run_code;
    logic [chuff_pkg::LEN_W-1:0]   n_run_len;
    logic [6:0]                    n_buf;
    logic [2:0]                    n_cnt;

    logic                          adv;
    logic                          assign_ok;
    logic [chuff_pkg::LEN_W-1:0]   shift_diff;
    logic [chuff_pkg::CODE_W:0]    shifted;
    logic [chuff_pkg::LEN_W-1:0]   clen;
    logic [38:0]                   acc;
    logic [chuff_pkg::LEN_W-1:0]   total;
    logic [39:0]                   aligned;
    logic [3:0]                    pad;
    logic [7:0]                    pad_byte;
    chuff_pkg::t_tbl_wr            wr_req;

    // Assign checks: length range, order, symbol range and fit of the shifted code.
    always_comb begin
        shift_diff = r_len - r_run_len;
        shifted    = r_run_code << shift_diff;
        assign_ok  = 1'b1;
        if (r_len == '0) begin
            assign_ok = 1'b0;
        end
        if ({1'b0, r_len} > 7'(chuff_pkg::MAX_CODE_LEN)
                || {1'b0, r_len} > 7'(chuff_pkg::CODE_W)) begin
            assign_ok = 1'b0;
        end
        if (r_len < r_run_len) begin
            assign_ok = 1'b0;
        end
        if ({1'b0, r_sym} >= 9'(chuff_pkg::SYMBOL_COUNT)) begin
            assign_ok = 1'b0;
        end
        if ((shifted >> r_len) != '0) begin
            assign_ok = 1'b0;
        end
    end

    // Encode datapath: append the code, left-align and cut full bytes.
    always_comb begin
        clen    = i_rd.hit ? i_rd.len : '0;
        acc     = ({32'd0, r_buf} << clen) | {7'd0, i_rd.code};
        total   = {3'd0, r_cnt} + clen;
        aligned = {acc, 1'b0} << (6'd39 - total);
    end

    // Flush: pad count and the padded partial byte.
    always_comb begin
        pad      = 4'd8 - {1'b0, r_cnt};
        pad_byte = {1'b0, r_buf} << pad;
    end

    // Result packet and next state for the request in the work stage.
    always_comb begin
        o_pkt      = '0;
        wr_req     = '0;
        n_run_code = r_run_code;
        n_run_len  = r_run_len;
        n_buf      = r_buf;
        n_cnt      = r_cnt;
        if (r_s1_valid) begin
            unique case (r_kind)
                chuff_pkg::KIND_ASSIGN: begin
                    o_pkt.any      = 1'b1;
                    o_pkt.last_idx = 2'd0;
                    o_pkt.error    = !assign_ok;
                    if (assign_ok) begin
                        wr_req.en   = 1'b1;
                        wr_req.sym  = r_sym;
                        wr_req.len  = r_len;
                        wr_req.code = shifted[chuff_pkg::CODE_W-1:0];
                        n_run_code  = shifted + 33'd1;
                        n_run_len   = r_len;
                    end
                end
                chuff_pkg::KIND_ENCODE: begin
                    if (clen != '0) begin
                        o_pkt.any        = total[5:3] != 3'd0;
                        o_pkt.byte_valid = 1'b1;
                        o_pkt.last_idx   = 2'(total[5:3] - 3'd1);
                        o_pkt.bytes[0]   = aligned[39:32];
                        o_pkt.bytes[1]   = aligned[31:24];
                        o_pkt.bytes[2]   = aligned[23:16];
                        o_pkt.bytes[3]   = aligned[15:8];
                        n_cnt            = total[2:0];
                        n_buf            = acc[6:0] & ~(7'h7F << total[2:0]);
                    end
                end
                chuff_pkg::KIND_FLUSH: begin
                    o_pkt.any        = 1'b1;
                    o_pkt.byte_valid = 1'b1;
                    if (r_cnt != 3'd0) begin
                        o_pkt.bytes[0] = pad_byte;
                        o_pkt.bytes[1] = {4'd0, pad};
                        o_pkt.last_idx = 2'd1;
                    end else begin
                        o_pkt.bytes[0] = {4'd0, pad};
                        o_pkt.last_idx = 2'd0;
                    end
                    n_buf = '0;
                    n_cnt = '0;
                end
                default: begin
                    // Unused kind: no results, no change.
                end
            endcase
        end
    end

    // Nothing commits unless the work stage advances.
    always_comb begin
        o_wr    = wr_req;
        o_wr.en = wr_req.en && adv;
    end

    // The stage advances when its results have somewhere to go.
    assign adv    = r_s1_valid && (!o_pkt.any || i_out_ready);
    assign o_load = adv && o_pkt.any;
    assign o_busy = r_s1_valid && !adv;

    // Work stage request register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_kind <= i_kind;
            r_sym  <= i_symbol;
            r_len  <= i_code_length;
        end
    end

    // Running code and bit buffer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_code <= '0;
            r_run_len  <= '0;
            r_buf      <= '0;
            r_cnt      <= '0;
        end else if (adv) begin
            r_run_code <= n_run_code;
            r_run_len  <= n_run_len;
            r_buf      <= n_buf;
            r_cnt      <= n_cnt;
        end
    end

    // A flush always leaves the bit buffer empty.
    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_kind == chuff_pkg::KIND_FLUSH) |=> (r_cnt == 3'd0 && r_buf == '0))
        else $error("bit buffer not empty after flush");

    // Code lengths handed out never decrease.
    a_len_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_run_len >= $past(r_run_len))
        else $error("running code length decreased");

    // An error is only reported on a status result.
    a_error_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load && o_pkt.error |-> !o_pkt.byte_valid && o_pkt.last_idx == 2'd0)
        else $error("error flag on a byte result");

endmodule

[rtl/chuff_out.sv]
// ----------------------------------------------------------------------------
// chuff_out
// Result register: holds the packet of one request and hands its results
// out one per cycle while i_stall is low.
// ----------------------------------------------------------------------------
module chuff_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  chuff_pkg::t_packet   i_pkt,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_byte_valid,
    output logic                 o_last,
    output logic                 o_error
);

    logic               r_valid;
    chuff_pkg::t_packet r_pkt;
    logic [1:0]         r_idx;
    logic               take;
    logic               at_last;

    assign at_last = r_idx == r_pkt.last_idx;
    assign take    = r_valid && !i_stall;
    assign o_ready = !r_valid || (take && at_last);

    // Packet register and result index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take) begin
            if (at_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pkt <= i_pkt;
        end
    end

    // Current result.
    assign o_valid      = r_valid;
    assign o_out_byte   = r_pkt.bytes[r_idx];
    assign o_byte_valid = r_pkt.byte_valid;
    assign o_last       = at_last;
    assign o_error      = r_pkt.error;

    // The index never runs past the packet's last result.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_idx <= r_pkt.last_idx)
        else $error("result index past end of packet");

    // A status result is always a packet of its own.
    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_pkt.byte_valid) |-> r_pkt.last_idx == 2'd0)
        else $error("status result with more than one entry");

    // A new packet only arrives when the current one is done.
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_ready)
        else $error("packet loaded over an unfinished one");

endmodule

[rtl/canonical_huffman_encoder.sv]
// ----------------------------------------------------------------------------
// canonical_huffman_encoder
// Canonical Huffman code assignment and bit packing into output bytes.
// ----------------------------------------------------------------------------
// A request enters the work stage in the cycle after it is accepted; its
// packet moves on into the result register once that register is free,
// and the first result is presented from there. Assigns, encodes that
// complete at most one byte, flushes of an empty buffer and ignored
// requests sustain one request per cycle while the output is not stalled,
// while an encode that completes up to four bytes or a flush with a partial
// byte holds the input, as results leave one per cycle when not stalled.
// The code table is a 256-entry memory with one write and one read port;
// symbols read as unassigned after reset through per-symbol assigned bits,
// so no clearing pass is needed and requests are taken right after reset.
module canonical_huffman_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [chuff_pkg::KIND_W-1:0]  i_kind,
    input  logic [chuff_pkg::SYM_W-1:0]   i_symbol,
    input  logic [chuff_pkg::LEN_W-1:0]   i_code_length,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_out_byte,
    output logic                          o_byte_valid,
    output logic                          o_last,
    output logic                          o_error
);

    logic               accept;
    logic               busy;
    logic               out_ready;
    logic               load;
    chuff_pkg::t_tbl_wr tbl_wr;
    chuff_pkg::t_tbl_rd tbl_rd;
    chuff_pkg::t_packet pkt;

    // A request is taken whenever the work stage is free or draining.
    assign o_stall = busy;
    assign accept  = i_valid && !busy;

    chuff_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept),
        .i_rd_sym (i_symbol),
        .i_wr     (tbl_wr),
        .o_rd     (tbl_rd)
    );

    chuff_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_kind        (i_kind),
        .i_symbol      (i_symbol),
        .i_code_length (i_code_length),
        .i_rd          (tbl_rd),
        .i_out_ready   (out_ready),
        .o_busy        (busy),
        .o_wr          (tbl_wr),
        .o_pkt         (pkt),
        .o_load        (load)
    );

    chuff_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_pkt        (pkt),
        .o_ready      (out_ready),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .o_error      (o_error)
    );

endmodule
